// ===== hdl/chff_pkg.sv =====
package chff_pkg;

	localparam int SAMPLE_BITS_DEF       = 12;
	localparam int CORDIC_ITERATIONS_DEF = 16;

	// Readings are scaled up by this many bits before the rotations.
	localparam int GUARD_SHIFT = 30;
	localparam int TABLE_LEN   = 24;

	// Angle accumulator counts 1/256 of a hundredth of a degree.
	localparam int ANGLE_W = 24;
	localparam int SUM_W   = 18;
	localparam int DECL_W  = 16;
	localparam int HEAD_W  = 16;

	localparam logic signed [ANGLE_W-1:0] HALF_TURN_FINE  = 24'sd4608000;
	localparam logic signed [ANGLE_W-1:0] ROUND_HALF_FINE = 24'sd128;
	localparam logic signed [SUM_W-1:0]   FULL_TURN       = 18'sd36000;
	localparam logic signed [SUM_W-1:0]   TWO_TURNS       = 18'sd72000;
	localparam logic signed [DECL_W-1:0]  DECL_RESET      = -16'sd1150;

	typedef logic signed [ANGLE_W-1:0] angle_t;

	// atan(2^-i) in accumulator units, rounded to nearest.
	function automatic angle_t atan_fine(input int i);
		angle_t r;
		case (i)
			0:       r = 24'sd1152000;
			1:       r = 24'sd680065;
			2:       r = 24'sd359328;
			3:       r = 24'sd182400;
			4:       r = 24'sd91554;
			5:       r = 24'sd45822;
			6:       r = 24'sd22916;
			7:       r = 24'sd11459;
			8:       r = 24'sd5730;
			9:       r = 24'sd2865;
			10:      r = 24'sd1432;
			11:      r = 24'sd716;
			12:      r = 24'sd358;
			13:      r = 24'sd179;
			14:      r = 24'sd90;
			15:      r = 24'sd45;
			16:      r = 24'sd22;
			17:      r = 24'sd11;
			18:      r = 24'sd6;
			19:      r = 24'sd3;
			20:      r = 24'sd1;
			21:      r = 24'sd1;
			default: r = 24'sd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/compass_heading_from_field.sv =====
// Stages in order: the fold entry stage, the CORDIC rotation stages, the declination sum stage and the output register.
// Throughput: one field pair per cycle while the output is not stalled; one CORDIC rotation per pipeline stage.
// A stalled output holds its beat while empty stages further up keep filling.
// Reset clears all stage valid bits and sets the declination to -11.50 degrees.
module compass_heading_from_field #(
	parameter int SAMPLE_BITS       = chff_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_ITERATIONS = chff_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic signed [chff_pkg::DECL_W-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_BITS-1:0]        field_x,
	input  logic signed [SAMPLE_BITS-1:0]        field_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic        [chff_pkg::HEAD_W-1:0]   heading_centideg
);

	localparam int N = (CORDIC_ITERATIONS > chff_pkg::TABLE_LEN) ?
		chff_pkg::TABLE_LEN : CORDIC_ITERATIONS;
	// Gain of the rotations and the negation need three bits of headroom.
	localparam int W = SAMPLE_BITS + chff_pkg::GUARD_SHIFT + 3;
	localparam int AW = chff_pkg::ANGLE_W;
	localparam int SW = chff_pkg::SUM_W;

	logic signed [chff_pkg::DECL_W-1:0] decl_q;

	logic signed [W-1:0]  x_s    [0:N];
	logic signed [W-1:0]  y_s    [0:N];
	logic signed [AW-1:0] z_s    [0:N];
	logic                 zero_s [0:N];
	logic                 v_s    [0:N];
	logic                 en_s   [0:N];

	logic signed [SW-1:0] sum_s;
	logic                 sum_v_s;
	logic                 en_sum;
	logic                 en_out;

	logic signed [W-1:0]  x_in;
	logic signed [W-1:0]  y_in;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= chff_pkg::DECL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			decl_q <= cfg_data;
		end
	end

	// A stage loads when it is empty or its content moves on this cycle.
	assign en_out = !out_valid || !out_stall;
	assign en_sum = !sum_v_s || en_out;
	assign en_s[N] = !v_s[N] || en_sum;

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_en
			assign en_s[k] = !v_s[k] || en_s[k+1];
		end
	endgenerate

	assign in_stall = !en_s[0];

	assign x_in = W'(field_x) <<< chff_pkg::GUARD_SHIFT;
	assign y_in = W'(field_y) <<< chff_pkg::GUARD_SHIFT;

	// Entry stage: fold the left half plane onto the right one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en_s[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s[0]) begin
			zero_s[0] <= (field_x == '0) && (field_y == '0);
			if (x_in < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= (y_in >= 0) ? chff_pkg::HALF_TURN_FINE : -chff_pkg::HALF_TURN_FINE;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	generate
		for (k = 1; k <= N; k++) begin : g_rot
			localparam logic signed [AW-1:0] ATAN_K = chff_pkg::atan_fine(k - 1);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en_s[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en_s[k]) begin
					zero_s[k] <= zero_s[k-1];
					if (y_s[k-1] >= 0) begin
						x_s[k] <= x_s[k-1] + (y_s[k-1] >>> (k - 1));
						y_s[k] <= y_s[k-1] - (x_s[k-1] >>> (k - 1));
						z_s[k] <= z_s[k-1] + ATAN_K;
					end else begin
						x_s[k] <= x_s[k-1] - (y_s[k-1] >>> (k - 1));
						y_s[k] <= y_s[k-1] + (x_s[k-1] >>> (k - 1));
						z_s[k] <= z_s[k-1] - ATAN_K;
					end
				end
			end
		end
	endgenerate

	// Round to whole hundredths and add the declination.
	logic signed [AW:0]   z_round;
	logic signed [AW-8:0] angle_c;

	always_comb begin
		z_round = (AW+1)'(z_s[N]) + (AW+1)'(chff_pkg::ROUND_HALF_FINE);
		angle_c = zero_s[N] ? '0 : z_round[AW:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_v_s <= 1'b0;
		end else if (en_sum) begin
			sum_v_s <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en_sum) begin
			sum_s <= SW'(angle_c) + SW'(decl_q);
		end
	end

	// The sum never leaves -2 to +2 turns, so one corrective step suffices.
	logic signed [SW-1:0] wrap_c;

	always_comb begin
		if (sum_s < -chff_pkg::FULL_TURN) begin
			wrap_c = sum_s + chff_pkg::TWO_TURNS;
		end else if (sum_s < 0) begin
			wrap_c = sum_s + chff_pkg::FULL_TURN;
		end else if (sum_s >= chff_pkg::FULL_TURN) begin
			wrap_c = sum_s - chff_pkg::FULL_TURN;
		end else begin
			wrap_c = sum_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= sum_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			heading_centideg <= wrap_c[chff_pkg::HEAD_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading_centideg < chff_pkg::HEAD_W'(36000)))
		else $error("heading out of range");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && sum_v_s && v_s[0]))
		else $error("input stalled while the pipeline has room");

	a_entry_right_half: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] |-> (x_s[0] >= 0))
		else $error("entry stage holds a vector in the left half plane");

	a_final_right_half: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N] |-> (x_s[N] >= 0))
		else $error("rotation left the right half plane");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

	localparam int     FIELD_W     = 12;
	localparam int     ROTATIONS   = 16;
	localparam int     STEP_COUNT  = 24;
	localparam int     GUARD       = 30;
	localparam longint HALF_TURN   = 64'sd4608000;
	localparam longint FULL_CIRCLE = 64'sd36000;
	localparam int     PER_PHASE   = 210;
	localparam int     PLANNED     = 1700;
	localparam int     NO_TYPED    = -1;

	// atan(2^-i) in 1/256 of a hundredth of a degree.
	localparam longint ATAN_STEP [STEP_COUNT] = '{
		1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
		5730, 2865, 1432, 716, 358, 179, 90, 45,
		22, 11, 6, 3, 1, 1, 0, 0
	};

	typedef logic signed [FIELD_W-1:0] field_t;

	typedef struct {
		field_t fx;
		field_t fy;
		int     typed;
	} probe_row_t;

	typedef struct {
		field_t                         fx;
		field_t                         fy;
		logic [chff_pkg::HEAD_W-1:0]    heading;
	} heading_entry_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic signed [chff_pkg::DECL_W-1:0]  cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	field_t                              field_x = '0;
	field_t                              field_y = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [chff_pkg::HEAD_W-1:0]         heading_centideg;

	heading_entry_t                      pending_headings[$];
	logic signed [chff_pkg::DECL_W-1:0]  declination = chff_pkg::DECL_RESET;
	int                                  send_idle_pct = 14;
	int                                  recv_stall_pct = 51;
	int                                  beats_in = 0;
	int                                  beats_out = 0;
	int                                  mismatch_count = 0;
	int                                  decl_settings = 1;

	compass_heading_from_field dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.field_x          (field_x),
		.field_y          (field_y),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.heading_centideg (heading_centideg)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("compass_heading_from_field verification failed");
		$finish;
	end

	function automatic logic [chff_pkg::HEAD_W-1:0] predict_heading(
		input field_t fx, input field_t fy,
		input logic signed [chff_pkg::DECL_W-1:0] decl);
		longint vx, vy, acc, dx, dy, angle, total;
		vx = fx;
		vy = fy;
		acc = 0;
		if (vx != 0 || vy != 0) begin
			vx = vx <<< GUARD;
			vy = vy <<< GUARD;
			// Fold the left half-plane over so the rotations only cover +-90 degrees.
			if (vx < 0) begin
				acc = (vy >= 0) ? HALF_TURN : -HALF_TURN;
				vx = -vx;
				vy = -vy;
			end
			for (int i = 0; i < ROTATIONS && i < STEP_COUNT; i++) begin
				dx = vy >>> i;
				dy = vx >>> i;
				if (vy >= 0) begin
					vx = vx + dx;
					vy = vy - dy;
					acc = acc + ATAN_STEP[i];
				end else begin
					vx = vx - dx;
					vy = vy + dy;
					acc = acc - ATAN_STEP[i];
				end
			end
		end
		angle = (acc + 128) >>> 8;
		total = (angle + longint'(decl)) % FULL_CIRCLE;
		if (total < 0)
			total = total + FULL_CIRCLE;
		return total[chff_pkg::HEAD_W-1:0];
	endfunction

	function automatic void set_idle_mode();
		int third;
		third = beats_in * 3 / PLANNED;
		if (third == 0) begin
			send_idle_pct = 14;
			recv_stall_pct = 51;
		end else if (third == 1) begin
			send_idle_pct = 51;
			recv_stall_pct = 14;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
	endfunction

	// One input beat; the expectation is queued at the edge that accepts it.
	task automatic send_pair(input field_t fx, input field_t fy, input int typed);
		heading_entry_t entry;
		set_idle_mode();
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		field_x <= fx;
		field_y <= fy;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		entry.fx = fx;
		entry.fy = fy;
		if (typed == NO_TYPED)
			entry.heading = predict_heading(fx, fy, declination);
		else
			entry.heading = typed[chff_pkg::HEAD_W-1:0];
		pending_headings.push_back(entry);
		beats_in++;
	endtask

	task automatic write_declination(input logic signed [chff_pkg::DECL_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_headings.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		declination = value;
		decl_settings++;
	endtask

	function automatic field_t any_extreme();
		case ($urandom_range(4))
			0:       return field_t'(-2048);
			1:       return field_t'(2047);
			2:       return field_t'(-1);
			3:       return field_t'(1);
			default: return field_t'(0);
		endcase
	endfunction

	task automatic send_random_pairs(input int count);
		field_t fx, fy;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				fx = field_t'($urandom);
				fy = field_t'($urandom);
			end else if (pick < 80) begin
				fx = field_t'(int'($urandom_range(16)) - 8);
				fy = field_t'(int'($urandom_range(16)) - 8);
			end else if (pick < 85) begin
				fx = '0;
				fy = '0;
			end else if (pick < 92) begin
				fx = field_t'($urandom);
				fy = '0;
				if ($urandom_range(1) == 1) begin
					fy = fx;
					fx = '0;
				end
			end else begin
				fx = any_extreme();
				fy = any_extreme();
			end
			send_pair(fx, fy, NO_TYPED);
		end
	endtask

	always @(posedge clk) begin
		heading_entry_t want;
		if (out_valid && !out_stall) begin
			beats_out++;
			if (pending_headings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected heading beat: got %0d", heading_centideg);
			end else begin
				want = pending_headings.pop_front();
				if (heading_centideg !== want.heading) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("heading mismatch for field (%0d, %0d): expected %0d, got %0d",
							want.fx, want.fy, want.heading, heading_centideg);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	probe_row_t probes[] = '{
		'{12'sd0,     12'sd0,     34850},
		'{12'sd2047,  12'sd0,     NO_TYPED},
		'{-12'sd2048, 12'sd0,     NO_TYPED},
		'{12'sd0,     12'sd2047,  NO_TYPED},
		'{12'sd0,     -12'sd2048, NO_TYPED},
		'{12'sd2047,  12'sd2047,  NO_TYPED},
		'{-12'sd2048, -12'sd2048, NO_TYPED},
		'{12'sd2047,  -12'sd2048, NO_TYPED},
		'{-12'sd2048, 12'sd2047,  NO_TYPED},
		'{12'sd1,     12'sd0,     NO_TYPED},
		'{-12'sd1,    12'sd0,     NO_TYPED},
		'{12'sd0,     12'sd1,     NO_TYPED},
		'{12'sd0,     -12'sd1,    NO_TYPED},
		'{12'sd1,     12'sd1,     NO_TYPED},
		'{-12'sd1,    -12'sd1,    NO_TYPED},
		'{-12'sd1,    12'sd1,     NO_TYPED},
		'{12'sd1,     -12'sd1,    NO_TYPED},
		'{12'sd2047,  12'sd1,     NO_TYPED},
		'{-12'sd2048, -12'sd1,    NO_TYPED},
		'{-12'sd2048, 12'sd1,     NO_TYPED},
		'{12'sd0,     12'sd0,     34850}
	};

	logic signed [chff_pkg::DECL_W-1:0] decl_plan[] = '{
		16'sd0, 16'sd18000, -16'sd18000, 16'sd32767, -16'sd32768, 16'sd9000
	};

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (probes[i])
			send_pair(probes[i].fx, probes[i].fy, probes[i].typed);
		send_random_pairs(PER_PHASE);

		foreach (decl_plan[i]) begin
			write_declination(decl_plan[i]);
			// The zero vector reads the declination straight back, wrapped once.
			send_pair('0, '0, int'(predict_heading('0, '0, decl_plan[i])));
			send_random_pairs(PER_PHASE);
		end
		write_declination(16'($urandom));
		send_random_pairs(PER_PHASE);

		in_valid <= 1'b0;
		while (pending_headings.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d field pairs and checked %0d headings over %0d declination settings,",
			beats_in, beats_out, decl_settings);
		$display("with back-pressure on either side and then none; %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0)
			$display("compass_heading_from_field verification clean");
		else
			$display("compass_heading_from_field verification failed");
		$finish;
	end

endmodule
